### hdl/brlr_pkg.sv
// ----------------------------------------------------------------------------
// brlr_pkg
// Shared constants, codes and beat types for the button run-length recorder.
// ----------------------------------------------------------------------------
package brlr_pkg;

   // Store geometry
   localparam int ENTRIES = 2048;
   localparam int ADDR_W  = $clog2(ENTRIES);

   // Fixed field widths
   localparam int FUNC_W = 3;
   localparam int BTN_W  = 16;
   localparam int CNT_W  = 8;
   localparam int IDX_W  = 11;
   localparam int MODE_W = 3;

   localparam logic [BTN_W-1:0]  END_MARK   = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
   localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(ENTRIES - 1);

   // Operation codes carried in func
   localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_RECORD    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_PLAY_IDLE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_PLAY_DONE = 3'd3;
   localparam logic [FUNC_W-1:0] FN_LOAD      = 3'd4;
   localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;

   // Mode codes as reported on mode_now
   localparam logic [MODE_W-1:0] MODE_CODE_IDLE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_PLAY_IDLE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_PLAY_DONE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_REC       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CODE_DONE      = 3'd4;

   // Recorder mode, held one-hot
   typedef enum logic [4:0] {
      M_IDLE      = 5'b00001,
      M_PLAY_IDLE = 5'b00010,
      M_PLAY_DONE = 5'b00100,
      M_REC       = 5'b01000,
      M_DONE      = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BTN_W-1:0]  pad_buttons;
      logic              start_pressed;
      logic              stop_pressed;
      logic [IDX_W-1:0]  entry_index;
      logic [BTN_W-1:0]  entry_buttons;
      logic [CNT_W-1:0]  entry_count;
   } req_type;

   typedef struct packed {
      logic [BTN_W-1:0]  buttons_out;
      logic              override_valid;
      logic [MODE_W-1:0] mode_now;
      logic [IDX_W-1:0]  position;
      logic              overflow;
      logic              finished;
      logic [BTN_W-1:0]  read_buttons;
      logic [CNT_W-1:0]  read_count;
   } rsp_type;

   // Store read request: port A and port B share one enable
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } mem_rd_type;

   typedef struct packed {
      logic              btn_we;
      logic [ADDR_W-1:0] btn_addr;
      logic [BTN_W-1:0]  btn_data;
      logic              cnt_we;
      logic [ADDR_W-1:0] cnt_addr;
      logic [CNT_W-1:0]  cnt_data;
   } mem_wr_type;

   typedef struct packed {
      logic [BTN_W-1:0] a_btn;
      logic [CNT_W-1:0] a_cnt;
      logic [BTN_W-1:0] b_btn;
      logic [CNT_W-1:0] b_cnt;
   } mem_q_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      unique case (m)
         M_IDLE:      c = MODE_CODE_IDLE;
         M_PLAY_IDLE: c = MODE_CODE_PLAY_IDLE;
         M_PLAY_DONE: c = MODE_CODE_PLAY_DONE;
         M_REC:       c = MODE_CODE_REC;
         M_DONE:      c = MODE_CODE_DONE;
         default:     c = MODE_CODE_IDLE;
      endcase
      return c;
   endfunction

   function automatic logic index_ok(input logic [IDX_W-1:0] idx);
      return (32'(idx) < ENTRIES);
   endfunction

endpackage

### hdl/brlr_store.sv
// ----------------------------------------------------------------------------
// brlr_store
// Entry store: button words and run counts in two synchronous memories, one
// write port each and two registered read ports.
// ----------------------------------------------------------------------------
module brlr_store
   import brlr_pkg::*;
(
   input  logic       clock,
   input  mem_rd_type rd,
   input  mem_wr_type wr,
   output mem_q_type  q
);

   logic [BTN_W-1:0] btn_mem [ENTRIES];
   logic [CNT_W-1:0] cnt_mem [ENTRIES];
   mem_q_type        q_ff;

   // Write button words
   always_ff @(posedge clock) begin
      if (wr.btn_we) begin
         btn_mem[wr.btn_addr] <= wr.btn_data;
      end
   end

   // Write run counts
   always_ff @(posedge clock) begin
      if (wr.cnt_we) begin
         cnt_mem[wr.cnt_addr] <= wr.cnt_data;
      end
   end

   // Read both ports; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         q_ff.a_btn <= btn_mem[rd.addr_a];
         q_ff.a_cnt <= cnt_mem[rd.addr_a];
         q_ff.b_btn <= btn_mem[rd.addr_b];
         q_ff.b_cnt <= cnt_mem[rd.addr_b];
      end
   end

   assign q = q_ff;

endmodule

### hdl/brlr_ctrl.sv
// ----------------------------------------------------------------------------
// brlr_ctrl
// Read-modify-write sequencer: fetches the current and next entry, applies
// the record or playback step, writes back and registers the result beat.
// ----------------------------------------------------------------------------
module brlr_ctrl
   import brlr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  req_type    item,
   output logic       item_take,
   output mem_rd_type rd,
   output mem_wr_type wr,
   input  mem_q_type  q,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp
);

   typedef enum logic [1:0] {
      E_FETCH = 2'b01,
      E_EXEC  = 2'b10
   } eng_type;

   eng_type           state_ff, state_in;
   req_type           item_ff;
   mode_type          mode_ff, mode_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_ff, rsp_in;

   logic              fire;
   logic              at_last;
   logic [ADDR_W-1:0] ptr_nx;
   logic              use_b;
   logic [BTN_W-1:0]  cur_btn;
   logic [CNT_W-1:0]  cur_cnt;
   logic [ADDR_W-1:0] cur_ptr;
   logic              playing;
   logic              play_end;
   mem_wr_type        wr_c;

   assign at_last = (ptr_ff == LAST_ENTRY);
   assign ptr_nx  = at_last ? ptr_ff : ptr_ff + 1'b1;
   assign playing = (mode_ff == M_PLAY_IDLE) || (mode_ff == M_PLAY_DONE);

   // Issue the store reads when a beat is taken from the input buffer
   assign item_take = (state_ff == E_FETCH) && item_valid;

   always_comb begin
      rd.en     = item_take;
      rd.addr_b = ptr_nx;
      if (item.func == FN_READ && index_ok(item.entry_index)) begin
         rd.addr_a = ADDR_W'(item.entry_index);
      end else begin
         rd.addr_a = ptr_ff;
      end
   end

   // Select the entry that playback works on
   assign use_b   = (q.a_cnt == '0);
   assign cur_btn = use_b ? q.b_btn : q.a_btn;
   assign cur_cnt = use_b ? q.b_cnt : q.a_cnt;
   assign cur_ptr = use_b ? ptr_nx : ptr_ff;

   // Commit the step once the result register is free
   assign fire = (state_ff == E_EXEC) && (!rsp_vld_ff || rsp_ready);

   always_comb begin
      mode_in  = mode_ff;
      ptr_in   = ptr_ff;
      wr_c     = '0;
      rsp_in   = '0;
      play_end = 1'b0;

      unique case (item_ff.func)
         FN_TICK: begin
            if (playing) begin
               if (use_b && at_last) begin
                  play_end = 1'b1;
               end else begin
                  ptr_in = cur_ptr;
                  if (cur_btn == END_MARK || item_ff.start_pressed) begin
                     play_end = 1'b1;
                  end else begin
                     rsp_in.buttons_out    = cur_btn;
                     rsp_in.override_valid = 1'b1;
                     wr_c.cnt_we           = 1'b1;
                     wr_c.cnt_addr         = cur_ptr;
                     wr_c.cnt_data         = cur_cnt - 1'b1;
                  end
               end
            end else if (mode_ff == M_REC) begin
               if (at_last) begin
                  rsp_in.overflow = 1'b1;
               end else if (item_ff.stop_pressed) begin
                  ptr_in          = ptr_nx;
                  wr_c.btn_we     = 1'b1;
                  wr_c.btn_addr   = ptr_nx;
                  wr_c.btn_data   = END_MARK;
                  mode_in         = M_IDLE;
                  rsp_in.finished = 1'b1;
               end else if (q.a_cnt != CNT_MAX && q.a_btn == item_ff.pad_buttons) begin
                  wr_c.cnt_we   = 1'b1;
                  wr_c.cnt_addr = ptr_ff;
                  wr_c.cnt_data = q.a_cnt + 1'b1;
               end else begin
                  ptr_in        = use_b ? ptr_ff : ptr_nx;
                  wr_c.btn_we   = 1'b1;
                  wr_c.btn_addr = use_b ? ptr_ff : ptr_nx;
                  wr_c.btn_data = item_ff.pad_buttons;
                  wr_c.cnt_we   = 1'b1;
                  wr_c.cnt_addr = use_b ? ptr_ff : ptr_nx;
                  wr_c.cnt_data = CNT_W'(1);
               end
            end
         end
         FN_RECORD: begin
            wr_c.btn_we   = 1'b1;
            wr_c.btn_addr = '0;
            wr_c.btn_data = '0;
            wr_c.cnt_we   = 1'b1;
            wr_c.cnt_addr = '0;
            wr_c.cnt_data = '0;
            ptr_in        = '0;
            mode_in       = M_REC;
         end
         FN_PLAY_IDLE: begin
            ptr_in  = '0;
            mode_in = M_PLAY_IDLE;
         end
         FN_PLAY_DONE: begin
            ptr_in  = '0;
            mode_in = M_PLAY_DONE;
         end
         FN_LOAD: begin
            if (index_ok(item_ff.entry_index)) begin
               wr_c.btn_we   = 1'b1;
               wr_c.btn_addr = ADDR_W'(item_ff.entry_index);
               wr_c.btn_data = item_ff.entry_buttons;
               wr_c.cnt_we   = 1'b1;
               wr_c.cnt_addr = ADDR_W'(item_ff.entry_index);
               wr_c.cnt_data = item_ff.entry_count;
            end
         end
         FN_READ: begin
            if (index_ok(item_ff.entry_index)) begin
               rsp_in.read_buttons = q.a_btn;
               rsp_in.read_count   = q.a_cnt;
            end
         end
         default: begin
         end
      endcase

      // End of playback drops to done or idle depending on the play mode
      if (play_end) begin
         mode_in = (mode_ff == M_PLAY_DONE) ? M_DONE : M_IDLE;
      end

      rsp_in.mode_now = mode_code(mode_in);
      rsp_in.position = IDX_W'(ptr_in);

      // Hold the store while the result register is full
      if (!fire) begin
         wr_c = '0;
      end
   end

   assign wr = wr_c;

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_FETCH: if (item_take) state_in = E_EXEC;
         E_EXEC:  if (fire) state_in = E_FETCH;
         default: state_in = E_FETCH;
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= E_FETCH;
         mode_ff    <= M_IDLE;
         ptr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (fire) begin
            mode_ff <= mode_in;
            ptr_ff  <= ptr_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (item_take) begin
         item_ff <= item;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

endmodule

### hdl/button_run_length_recorder_top.sv
// ----------------------------------------------------------------------------
// button_run_length_recorder_top
// Records a controller button word per frame as run-length entries and plays
// the recording back.
// ----------------------------------------------------------------------------
// Usage:
//   One req_ beat per frame or command (func selects tick, record start,
//   play, load or read). Every req_ beat gives exactly one rsp_ beat, in
//   order. Both channels use valid/ready.
//   Timing: a taken req_ beat waits in the input buffer, its entries are
//   read from the entry store, then updated, written back and registered
//   as the rsp_ beat. The read-then-writeback of the entry store ends
//   before the next beat is taken; a one-beat input buffer takes the next
//   beat while the current one is in the store.
//   Reset: mode goes idle, the entry pointer goes to zero; the entry store
//   is not cleared and its contents are undefined until written, so there
//   is no clearing pass and req_ready rises right after reset.
//   Stall: while rsp_ready is low the result is held in its register, the
//   store is not written, and req_ready drops once the input buffer fills.
// ----------------------------------------------------------------------------
module button_run_length_recorder_top
   import brlr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [BTN_W-1:0]  req_pad_buttons,
   input  logic              req_start_pressed,
   input  logic              req_stop_pressed,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [BTN_W-1:0]  req_entry_buttons,
   input  logic [CNT_W-1:0]  req_entry_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BTN_W-1:0]  rsp_buttons_out,
   output logic              rsp_override_valid,
   output logic [MODE_W-1:0] rsp_mode_now,
   output logic [IDX_W-1:0]  rsp_position,
   output logic              rsp_overflow,
   output logic              rsp_finished,
   output logic [BTN_W-1:0]  rsp_read_buttons,
   output logic [CNT_W-1:0]  rsp_read_count
);

   logic       buf_vld_ff;
   req_type    buf_ff;
   logic       take;
   mem_rd_type rd;
   mem_wr_type wr;
   mem_q_type  q;
   rsp_type    rsp;

   // Input buffer: take a beat whenever it is empty or being drained
   assign req_ready = !buf_vld_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         buf_vld_ff <= 1'b1;
      end else if (take) begin
         buf_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         buf_ff.func          <= req_func;
         buf_ff.pad_buttons   <= req_pad_buttons;
         buf_ff.start_pressed <= req_start_pressed;
         buf_ff.stop_pressed  <= req_stop_pressed;
         buf_ff.entry_index   <= req_entry_index;
         buf_ff.entry_buttons <= req_entry_buttons;
         buf_ff.entry_count   <= req_entry_count;
      end
   end

   brlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (buf_vld_ff),
      .item       (buf_ff),
      .item_take  (take),
      .rd         (rd),
      .wr         (wr),
      .q          (q),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   brlr_store u_store (
      .clock (clock),
      .rd    (rd),
      .wr    (wr),
      .q     (q)
   );

   assign rsp_buttons_out    = rsp.buttons_out;
   assign rsp_override_valid = rsp.override_valid;
   assign rsp_mode_now       = rsp.mode_now;
   assign rsp_position       = rsp.position;
   assign rsp_overflow       = rsp.overflow;
   assign rsp_finished       = rsp.finished;
   assign rsp_read_buttons   = rsp.read_buttons;
   assign rsp_read_count     = rsp.read_count;

endmodule

### hdl/brlr_checker.sv
// ----------------------------------------------------------------------------
// brlr_checker
// Port-level checks on the recorder's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module brlr_checker
   import brlr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BTN_W-1:0]  rsp_buttons_out,
   input logic              rsp_override_valid,
   input logic [MODE_W-1:0] rsp_mode_now,
   input logic [IDX_W-1:0]  rsp_position,
   input logic              rsp_overflow,
   input logic              rsp_finished,
   input logic [BTN_W-1:0]  rsp_read_buttons,
   input logic [CNT_W-1:0]  rsp_read_count
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_buttons_out)
         && $stable(rsp_mode_now) && $stable(rsp_position)
         && $stable(rsp_read_buttons) && $stable(rsp_read_count))
      else $error("result beat changed while stalled");

   // A replayed word only comes out while playback continues
   a_override_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_override_valid |->
         rsp_mode_now == MODE_CODE_PLAY_IDLE || rsp_mode_now == MODE_CODE_PLAY_DONE)
      else $error("override outside playback");

   // Without override the replayed word is zero
   a_override_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_override_valid |-> rsp_buttons_out == '0)
      else $error("replayed word without override");

   // Finishing a recording lands in idle and never flags overflow
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_mode_now == MODE_CODE_IDLE && !rsp_overflow)
      else $error("finished beat not idle");

   // Overflow only while recording, at the last entry
   a_overflow_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_mode_now == MODE_CODE_REC && rsp_position == IDX_W'(ENTRIES - 1))
      else $error("overflow outside full recording");

endmodule

bind button_run_length_recorder_top brlr_checker u_brlr_checker (.*);

### dv/button_run_length_recorder_top_tb.sv
// ----------------------------------------------------------------------------
// button_run_length_recorder_top_tb
// Self-checking bench for the run-length button recorder: a directed table,
// a record sweep that saturates one run and fills the store to overflow, and
// random record, playback and store-access sessions, all scored beat by beat
// against a behavioral model of the recorder, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module button_run_length_recorder_top_tb
   import brlr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800_000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_FRAMES = 200;

   // func codes that the block must treat as no-ops
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

   typedef struct packed {
      req_type cmd;
      logic    pin;
      rsp_type want;
   } plan_row_type;

   localparam rsp_type NO_WANT = '0;

   // Directed frames; rows with pin set carry a hand-written result
   localparam int PLAN_ROWS = 26;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{'{FN_TICK,      16'hFFFF, 1'b1, 1'b1, 11'h7FF, 16'hFFFF, 8'hFF}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_LOAD,      16'h0000, 1'b0, 1'b0, 11'h000, 16'hFFFF, 8'hFF}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_LOAD,      16'hFFFF, 1'b1, 1'b1, 11'h7FF, 16'h0000, 8'h00}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_LOAD,      16'h0000, 1'b0, 1'b0, 11'h002, 16'h1234, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_READ,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'hFFFF, 8'hFF}},
      '{'{FN_READ,      16'hFFFF, 1'b1, 1'b1, 11'h7FF, 16'hFFFF, 8'hFF}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_UNUSED_LO, 16'hFFFF, 1'b1, 1'b1, 11'h7FF, 16'hFFFF, 8'hFF}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_UNUSED_HI, 16'hFFFF, 1'b1, 1'b1, 11'h000, 16'hFFFF, 8'hFF}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_RECORD,    16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_REC, 11'd0, 1'b0, 1'b0, 16'h0000, 8'h00}},
      '{'{FN_TICK,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b1, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h8001, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h8001, 1'b0, 1'b1, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_READ,      16'h0000, 1'b0, 1'b0, 11'h001, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_READ,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_READ,      16'h0000, 1'b0, 1'b0, 11'h002, 16'h0000, 8'h00}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd2, 1'b0, 1'b0, 16'hFFFF, 8'h00}},
      '{'{FN_PLAY_DONE, 16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h5555, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'hAAAA, 1'b0, 1'b1, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b1, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_PLAY_IDLE, 16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b0, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_TICK,      16'h0000, 1'b1, 1'b0, 11'h000, 16'h0000, 8'h00}, 1'b0,
        NO_WANT},
      '{'{FN_READ,      16'h0000, 1'b0, 1'b0, 11'h001, 16'h0000, 8'h00}, 1'b1,
        '{16'h0000, 1'b0, MODE_CODE_IDLE, 11'd1, 1'b0, 1'b0, 16'h8001, 8'hFF}}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func;
   logic [BTN_W-1:0]  req_pad_buttons;
   logic              req_start_pressed;
   logic              req_stop_pressed;
   logic [IDX_W-1:0]  req_entry_index;
   logic [BTN_W-1:0]  req_entry_buttons;
   logic [CNT_W-1:0]  req_entry_count;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BTN_W-1:0]  rsp_buttons_out;
   logic              rsp_override_valid;
   logic [MODE_W-1:0] rsp_mode_now;
   logic [IDX_W-1:0]  rsp_position;
   logic              rsp_overflow;
   logic              rsp_finished;
   logic [BTN_W-1:0]  rsp_read_buttons;
   logic [CNT_W-1:0]  rsp_read_count;

   // Model of the recorder: run store, mode and entry pointer
   logic [BTN_W-1:0]  tape_btn [ENTRIES];
   logic [CNT_W-1:0]  tape_cnt [ENTRIES];
   logic [MODE_W-1:0] tape_mode = MODE_CODE_IDLE;
   logic [IDX_W-1:0]  tape_ptr = '0;

   rsp_type pending_frames [$];

   // Handshake side channel from the sender to the monitor
   logic    pin_flag = 1'b0;
   rsp_type pin_want = '0;
   logic    req_steady = 1'b0;
   int      rsp_hold_cycles = 0;

   int offered = 0;
   int mismatches = 0;
   int frames_checked = 0;
   int replayed = 0;
   int overflowed = 0;
   int closed = 0;
   int cycle_count = 0;

   button_run_length_recorder_top DUT (.*);

   always #5 clock = ~clock;

   // Advance the recorder model by one frame and return its result beat
   function automatic rsp_type step_recorder(input req_type c);
      rsp_type r;
      logic [IDX_W-1:0] p;
      r = '0;
      p = tape_ptr;
      case (c.func)
         FN_TICK: begin
            if (tape_mode == MODE_CODE_PLAY_IDLE || tape_mode == MODE_CODE_PLAY_DONE) begin
               if (tape_cnt[p] == '0 && p == LAST_ENTRY) begin
                  tape_mode = (tape_mode == MODE_CODE_PLAY_DONE) ? MODE_CODE_DONE
                                                                 : MODE_CODE_IDLE;
               end else begin
                  if (tape_cnt[p] == '0) begin
                     p = p + 1'b1;
                     tape_ptr = p;
                  end
                  if (tape_btn[p] == END_MARK || c.start_pressed) begin
                     tape_mode = (tape_mode == MODE_CODE_PLAY_DONE) ? MODE_CODE_DONE
                                                                    : MODE_CODE_IDLE;
                  end else begin
                     r.buttons_out = tape_btn[p];
                     r.override_valid = 1'b1;
                     tape_cnt[p] = tape_cnt[p] - 1'b1;
                  end
               end
            end else if (tape_mode == MODE_CODE_REC) begin
               if (p == LAST_ENTRY) begin
                  r.overflow = 1'b1;
               end else if (c.stop_pressed) begin
                  p = p + 1'b1;
                  tape_ptr = p;
                  tape_btn[p] = END_MARK;
                  tape_mode = MODE_CODE_IDLE;
                  r.finished = 1'b1;
               end else if (tape_cnt[p] != CNT_MAX && tape_btn[p] == c.pad_buttons) begin
                  tape_cnt[p] = tape_cnt[p] + 1'b1;
               end else begin
                  if (tape_cnt[p] != '0) begin
                     p = p + 1'b1;
                     tape_ptr = p;
                  end
                  tape_btn[p] = c.pad_buttons;
                  tape_cnt[p] = 8'd1;
               end
            end
         end
         FN_RECORD: begin
            tape_btn[0] = '0;
            tape_cnt[0] = '0;
            tape_ptr = '0;
            tape_mode = MODE_CODE_REC;
         end
         FN_PLAY_IDLE: begin
            tape_ptr = '0;
            tape_mode = MODE_CODE_PLAY_IDLE;
         end
         FN_PLAY_DONE: begin
            tape_ptr = '0;
            tape_mode = MODE_CODE_PLAY_DONE;
         end
         FN_LOAD: begin
            if (32'(c.entry_index) < ENTRIES) begin
               tape_btn[c.entry_index] = c.entry_buttons;
               tape_cnt[c.entry_index] = c.entry_count;
            end
         end
         FN_READ: begin
            if (32'(c.entry_index) < ENTRIES) begin
               r.read_buttons = tape_btn[c.entry_index];
               r.read_count = tape_cnt[c.entry_index];
            end
         end
         default: ;
      endcase
      r.mode_now = tape_mode;
      r.position = tape_ptr;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Score result beats, then predict the frame taken on this edge
   always @(posedge clock) begin : monitor
      rsp_type w;
      rsp_type p;
      req_type c;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               $error("result beat arrived with no frame pending");
               mismatches++;
            end else begin
               w = pending_frames.pop_front();
               compare_field("buttons_out", w.buttons_out, rsp_buttons_out);
               compare_field("override_valid", 16'(w.override_valid),
                             16'(rsp_override_valid));
               compare_field("mode_now", 16'(w.mode_now), 16'(rsp_mode_now));
               compare_field("position", 16'(w.position), 16'(rsp_position));
               compare_field("overflow", 16'(w.overflow), 16'(rsp_overflow));
               compare_field("finished", 16'(w.finished), 16'(rsp_finished));
               compare_field("read_buttons", w.read_buttons, rsp_read_buttons);
               compare_field("read_count", 16'(w.read_count), 16'(rsp_read_count));
               frames_checked++;
            end
         end
         if (req_valid && req_ready) begin
            c = '{req_func, req_pad_buttons, req_start_pressed, req_stop_pressed,
                  req_entry_index, req_entry_buttons, req_entry_count};
            p = step_recorder(c);
            replayed += int'(p.override_valid);
            overflowed += int'(p.overflow);
            closed += int'(p.finished);
            pending_frames.push_back(pin_flag ? pin_want : p);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames still pending",
                  cycle_count, pending_frames.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: random stall per beat, idle-free stretches, one long hold on request
   initial begin : rsp_side
      int gap;
      int beats;
      beats = 0;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if ((beats % 80) < 20) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
         @(negedge clock);
      end
   end

   // Offer one frame beat and hold it until taken; returns on the next falling edge
   task automatic offer(input req_type c, input logic pin = 1'b0,
                        input rsp_type want = '0);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func = c.func;
      req_pad_buttons = c.pad_buttons;
      req_start_pressed = c.start_pressed;
      req_stop_pressed = c.stop_pressed;
      req_entry_index = c.entry_index;
      req_entry_buttons = c.entry_buttons;
      req_entry_count = c.entry_count;
      pin_flag = pin;
      pin_want = want;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      offered++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every pending result plus the pipeline tail
   task automatic settle();
      req_valid = 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [BTN_W-1:0] corner_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return END_MARK;
         2: return 16'(1) << $urandom_range(0, 15);
         3: return ~(16'(1) << $urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type loose_fields(input logic [FUNC_W-1:0] f);
      req_type c;
      c.func = f;
      c.pad_buttons = 16'($urandom);
      c.start_pressed = 1'($urandom);
      c.stop_pressed = 1'($urandom);
      c.entry_index = 11'($urandom);
      c.entry_buttons = 16'($urandom);
      c.entry_count = 8'($urandom);
      return c;
   endfunction

   initial begin : stimulus
      req_type c;
      logic [BTN_W-1:0] pad;
      logic [BTN_W-1:0] next_pad;
      logic [BTN_W-1:0] palette [3];
      int k;
      int n;
      int stop_at;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FN_TICK;
      req_pad_buttons = '0;
      req_start_pressed = 1'b0;
      req_stop_pressed = 1'b0;
      req_entry_index = '0;
      req_entry_buttons = '0;
      req_entry_count = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (PLAN[i]) offer(PLAN[i].cmd, PLAN[i].pin, PLAN[i].want);
      settle();

      // Record until the store is full: one saturated run, then a new entry per frame;
      // hold the result side off early on while the sender keeps going
      rsp_hold_cycles = 150;
      c = loose_fields(FN_RECORD);
      offer(c);
      pad = corner_word();
      k = 0;
      repeat (256) begin
         req_steady = ((k / 100) % 4 == 0);
         c = loose_fields(FN_TICK);
         c.pad_buttons = pad;
         c.stop_pressed = 1'b0;
         offer(c);
         k++;
      end
      while (tape_ptr != LAST_ENTRY) begin
         req_steady = ((k / 100) % 4 == 0);
         next_pad = 16'($urandom);
         if (next_pad == pad) next_pad = ~pad;
         pad = next_pad;
         c = loose_fields(FN_TICK);
         c.pad_buttons = pad;
         c.stop_pressed = 1'b0;
         offer(c);
         k++;
      end
      // Store full: frames and even a stop press are refused
      for (k = 0; k < 3; k++) begin
         c = loose_fields(FN_TICK);
         c.stop_pressed = (k == 1);
         offer(c);
      end
      settle();

      // Random sessions
      rsp_hold_cycles = 120;
      stop_at = offered + RANDOM_FRAMES;
      while (offered < stop_at) begin
         req_steady = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               offer(loose_fields(FN_RECORD));
               foreach (palette[j]) palette[j] = corner_word();
               pad = palette[0];
               n = $urandom_range(4, 60);
               for (k = 0; k < n && tape_mode == MODE_CODE_REC; k++) begin
                  if ($urandom_range(0, 4) == 0) pad = palette[$urandom_range(0, 2)];
                  c = loose_fields(FN_TICK);
                  c.pad_buttons = pad;
                  c.stop_pressed = ($urandom_range(0, 39) == 0);
                  offer(c);
               end
               // Usually close the recording with a terminator
               if (tape_mode == MODE_CODE_REC && $urandom_range(0, 2) != 0) begin
                  c = loose_fields(FN_TICK);
                  c.pad_buttons = pad;
                  c.stop_pressed = 1'b1;
                  offer(c);
               end
            end
            3, 4, 5: begin
               offer(loose_fields($urandom_range(0, 1) ? FN_PLAY_IDLE : FN_PLAY_DONE));
               for (k = 0; k < 90 && (tape_mode == MODE_CODE_PLAY_IDLE ||
                                      tape_mode == MODE_CODE_PLAY_DONE); k++) begin
                  c = loose_fields(FN_TICK);
                  c.start_pressed = ($urandom_range(0, 39) == 0);
                  offer(c);
               end
            end
            6, 7: begin
               repeat ($urandom_range(1, 8)) begin
                  c = loose_fields($urandom_range(0, 1) ? FN_LOAD : FN_READ);
                  if ($urandom_range(0, 1)) c.entry_index = IDX_W'($urandom_range(0, 31));
                  c.entry_buttons = corner_word();
                  case ($urandom_range(0, 3))
                     0: c.entry_count = '0;
                     1: c.entry_count = CNT_MAX;
                     2: c.entry_count = 8'd1;
                     default: ;
                  endcase
                  offer(c);
               end
            end
            default: begin
               repeat ($urandom_range(1, 4)) offer(loose_fields(FUNC_W'($urandom_range(0, 7))));
            end
         endcase
      end
      settle();

      $display("Scored %0d frames: %0d replayed, %0d refused as overflow, %0d recordings closed.",
               frames_checked, replayed, overflowed, closed);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
